// ===== src/rrq_pkg.sv =====
// rrq_pkg: shared types and constants for the round-robin run queue
// no dependencies; imported by rrq_cell and round_robin_run_queue
`default_nettype none

package rrq_pkg;

    localparam int TASK_W        = 16;
    localparam int COUNT_OUT_W   = 6;
    localparam int DEF_QUEUE_DEPTH = 32;
    localparam int DEF_ID_WIDTH    = 16;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_TICK    = 2'd2,
        OP_PICK    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [TASK_W-1:0]  task_id;
    } t_cmd;

    typedef struct packed {
        logic [TASK_W-1:0]      head_task;
        logic                   head_valid;
        logic [COUNT_OUT_W-1:0] waiting_count;
        t_status                status;
    } t_result;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic enq;
        logic rem;
        logic tick;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== src/round_robin_run_queue.sv =====
// round_robin_run_queue: top level, a row of rrq_cell slots plus count and result registers
// depends on rrq_pkg and rrq_cell
// the result word strobes on o_done in the cycle after the command is taken
// throughput: one command per cycle while busy is low; every cell compares and shifts in the same cycle
// busy is high only during reset and the cycle after; the receiver cannot stall
// reset: synchronous, clears the valid bits, the count and the result strobe, and sets busy
`default_nettype none

module round_robin_run_queue
    import rrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_cmd    i_cmd,
    output logic         o_done,
    output t_result      o_result
);

    localparam int SLOT_W  = (ID_WIDTH < TASK_W) ? ID_WIDTH : TASK_W;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [SLOT_W-1:0]      w_slot [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH:0]   w_found;
    logic [SLOT_W-1:0]      w_id;
    t_cell_ctl              w_ctl;
    logic                   w_accept;
    logic                   w_full;

    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_done;
    logic               r_busy;
    t_status            r_status, n_status;

    assign w_accept   = start && !busy;
    assign w_id       = i_cmd.task_id[SLOT_W-1:0];
    assign w_full     = w_valid[QUEUE_DEPTH-1];
    assign w_found[0] = 1'b0;

    always_comb begin
        w_ctl.enq  = w_accept && (i_cmd.op == OP_ENQUEUE) && !w_full;
        w_ctl.rem  = w_accept && (i_cmd.op == OP_REMOVE);
        // rotate only with two or more tasks waiting
        w_ctl.tick = w_accept && (i_cmd.op == OP_TICK) && w_valid[1];
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic              w_prev_valid;
            logic [SLOT_W-1:0] w_next_slot;
            logic              w_next_valid;

            if (gi == 0) begin : g_first
                assign w_prev_valid = 1'b1;
            end else begin : g_inner
                assign w_prev_valid = w_valid[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_end
                assign w_next_slot  = w_slot[gi];
                assign w_next_valid = 1'b0;
            end else begin : g_mid
                assign w_next_slot  = w_slot[gi+1];
                assign w_next_valid = w_valid[gi+1];
            end

            rrq_cell #(
                .SLOT_W (SLOT_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_id         (w_id),
                .i_head_slot  (w_slot[0]),
                .i_prev_valid (w_prev_valid),
                .i_found      (w_found[gi]),
                .i_next_slot  (w_next_slot),
                .i_next_valid (w_next_valid),
                .o_slot       (w_slot[gi]),
                .o_valid      (w_valid[gi]),
                .o_found      (w_found[gi+1])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        if (w_accept) begin
            unique case (i_cmd.op)
                OP_ENQUEUE: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (w_found[QUEUE_DEPTH]) begin
                        n_count = r_count - 1'b1;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                OP_TICK, OP_PICK: begin
                    n_status = ST_OK;
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
            r_busy  <= 1'b1;
        end else begin
            r_count <= n_count;
            r_done  <= w_accept;
            r_busy  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    // cells and count already hold the post-command state during the strobe
    assign busy   = r_busy;
    assign o_done = r_done;
    always_comb begin
        o_result.head_task     = w_valid[0] ? TASK_W'(w_slot[0]) : '0;
        o_result.head_valid    = w_valid[0];
        o_result.waiting_count = COUNT_OUT_W'(r_count);
        o_result.status        = r_status;
    end

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) == $countones(w_valid))
        else $error("count differs from number of valid cells");

    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("valid cells are not packed toward the head");

    a_result_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_done)
        else $error("accepted command produced no result word");

    a_full_enqueue_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd.op == OP_ENQUEUE) && w_full)
        |=> (r_status == ST_FULL) && (r_count == $past(r_count)))
        else $error("enqueue into a full queue changed the count");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd.op == OP_REMOVE) && w_found[QUEUE_DEPTH])
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("successful remove did not shrink the queue");

endmodule

`default_nettype wire

// ===== src/rrq_cell.sv =====
// rrq_cell: one queue slot holding a task id and its valid bit
// talks to its left and right neighbors; depends on rrq_pkg
`default_nettype none

module rrq_cell
    import rrq_pkg::*;
#(
    parameter int SLOT_W = DEF_ID_WIDTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [SLOT_W-1:0] i_id,
    input  wire logic [SLOT_W-1:0] i_head_slot,
    input  wire logic              i_prev_valid,
    input  wire logic              i_found,
    input  wire logic [SLOT_W-1:0] i_next_slot,
    input  wire logic              i_next_valid,
    output logic      [SLOT_W-1:0] o_slot,
    output logic                   o_valid,
    output logic                   o_found
);

    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_valid, n_valid;
    logic              w_match;
    logic              w_last;

    assign w_match = r_valid && (r_slot == i_id);
    // found token: set from the first matching cell onward
    assign o_found = i_found | w_match;
    assign w_last  = r_valid && !i_next_valid;
    assign o_slot  = r_slot;
    assign o_valid = r_valid;

    always_comb begin
        n_slot  = r_slot;
        n_valid = r_valid;
        priority if (i_ctl.enq) begin
            if (!r_valid && i_prev_valid) begin
                n_slot  = i_id;
                n_valid = 1'b1;
            end
        end else if (i_ctl.rem) begin
            // close the gap: every cell at or past the match pulls from the right
            if (o_found) begin
                n_slot  = i_next_slot;
                n_valid = i_next_valid;
            end
        end else if (i_ctl.tick) begin
            if (w_last) begin
                n_slot = i_head_slot;
            end else if (r_valid) begin
                n_slot = i_next_slot;
            end
        end else begin
            // idle or pick: hold
            n_slot  = r_slot;
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule

`default_nettype wire
